### sv/smig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_pkg
// Shared types and constants of the sphere mesh index generator.
// ----------------------------------------------------------------------------
package smig_pkg;

	localparam int IDX_W  = 17;
	localparam int CFG_W  = 9;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam int DEF_MAX_SEGMENTS = 256;
	localparam int DEF_MAX_RINGS    = 256;

	localparam int MIN_SEGMENTS = 3;
	localparam int MIN_RINGS    = 1;

	localparam logic [CFG_W-1:0] RESET_SEGMENTS = CFG_W'(16);
	localparam logic [CFG_W-1:0] RESET_RINGS    = CFG_W'(8);

	// register index, taken from paddr[2]
	localparam logic REG_SEGMENTS = 1'b0;
	localparam logic REG_RINGS    = 1'b1;

	typedef enum logic [2:0] {
		SEC_TOP    = 3'b001,
		SEC_BAND   = 3'b010,
		SEC_BOTTOM = 3'b100
	} section_t;

endpackage

### sv/smig_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_req_if
// Request channel: one transfer asks for the next triangle.
// ----------------------------------------------------------------------------
interface smig_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

### sv/smig_tri_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smig_tri_if
// Triangle channel: three vertex indices and the end-of-mesh flag.
// ----------------------------------------------------------------------------
interface smig_tri_if;
	import smig_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] first_index;
	logic [IDX_W-1:0] second_index;
	logic [IDX_W-1:0] third_index;
	logic             last_triangle;

	modport source (output valid, output first_index, output second_index,
		output third_index, output last_triangle, input ready);
	modport sink (input valid, input first_index, input second_index,
		input third_index, input last_triangle, output ready);
endinterface

### sv/sphere_mesh_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_mesh_index_generator
// Walks the triangle list of a UV sphere: top-cap fan, bands, bottom-cap fan.
// ----------------------------------------------------------------------------
// a triangle is on the output in the cycle after its request transfer
// throughput: one triangle per cycle while triangle.ready is high, set by the single output register
// a new request is taken while the output register is empty or being drained
// reset: 16 segments, 8 rings, sequence at the first top-cap triangle
// any register write also restarts the sequence
module sphere_mesh_index_generator #(
	parameter int MAX_SEGMENTS = smig_pkg::DEF_MAX_SEGMENTS,
	parameter int MAX_RINGS    = smig_pkg::DEF_MAX_RINGS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [smig_pkg::ADDR_W-1:0] paddr,
	input  logic [smig_pkg::DATA_W-1:0] pwdata,
	output logic [smig_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	smig_req_if.sink                    req,
	smig_tri_if.source                  triangle
);
	import smig_pkg::*;

	localparam int S_W    = $clog2(MAX_SEGMENTS + 1);
	localparam int SEG_W  = $clog2(MAX_SEGMENTS);
	localparam int R_W    = $clog2(MAX_RINGS + 1);

	// configuration
	logic [CFG_W-1:0] segs_q;
	logic [CFG_W-1:0] rings_q;
	logic             cfg_wr;

	// sequence state
	section_t         sec_q;
	logic [R_W-1:0]   band_q;
	logic [SEG_W-1:0] seg_q;
	logic             half_q;
	logic [IDX_W-1:0] base_q;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] a_q, b_q, c_q;
	logic             last_q;

	logic             accept;

	logic [S_W-1:0]   s_eff;
	logic [R_W-1:0]   r_eff;
	logic             restart_cond;
	section_t         cur_sec;
	logic [R_W-1:0]   cur_band;
	logic [SEG_W-1:0] cur_seg;
	logic             cur_half;
	logic [IDX_W-1:0] cur_base;
	logic [S_W-1:0]   seg_inc;
	logic             wrap;
	logic [SEG_W-1:0] j;
	logic [IDX_W-1:0] ui, uj, li, lj, low_base;
	logic [R_W-1:0]   band_inc;

	section_t         sec_d;
	logic [R_W-1:0]   band_d;
	logic [SEG_W-1:0] seg_d;
	logic             half_d;
	logic [IDX_W-1:0] base_d;
	logic [IDX_W-1:0] a_d, b_d, c_d;
	logic             last_d;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_SEGMENTS: prdata = DATA_W'(segs_q);
			REG_RINGS:    prdata = DATA_W'(rings_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_q  <= RESET_SEGMENTS;
			rings_q <= RESET_RINGS;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_SEGMENTS: segs_q <= pwdata[CFG_W-1:0];
				REG_RINGS:    rings_q <= pwdata[CFG_W-1:0];
				default:      segs_q <= segs_q;
			endcase
		end
	end

	// clamp the registers to the supported range
	always_comb begin
		if (32'(segs_q) < MIN_SEGMENTS)
			s_eff = S_W'(MIN_SEGMENTS);
		else if (32'(segs_q) > MAX_SEGMENTS)
			s_eff = S_W'(MAX_SEGMENTS);
		else
			s_eff = S_W'(segs_q);
		if (32'(rings_q) < MIN_RINGS)
			r_eff = R_W'(MIN_RINGS);
		else if (32'(rings_q) > MAX_RINGS)
			r_eff = R_W'(MAX_RINGS);
		else
			r_eff = R_W'(rings_q);
	end

	assign restart_cond = req.restart
		|| !(sec_q == SEC_TOP || sec_q == SEC_BAND || sec_q == SEC_BOTTOM)
		|| (S_W'(seg_q) >= s_eff);

	assign cur_sec  = restart_cond ? SEC_TOP : sec_q;
	assign cur_band = restart_cond ? '0 : band_q;
	assign cur_seg  = restart_cond ? '0 : seg_q;
	assign cur_half = restart_cond ? 1'b0 : half_q;
	assign cur_base = restart_cond ? IDX_W'(1) : base_q;

	// neighbor segment, wrapping to zero
	assign seg_inc  = S_W'(cur_seg) + S_W'(1);
	assign wrap     = (seg_inc == s_eff);
	assign j        = wrap ? '0 : seg_inc[SEG_W-1:0];

	assign low_base = cur_base + IDX_W'(s_eff);
	assign ui       = cur_base + IDX_W'(cur_seg);
	assign uj       = cur_base + IDX_W'(j);
	assign li       = low_base + IDX_W'(cur_seg);
	assign lj       = low_base + IDX_W'(j);
	assign band_inc = cur_band + R_W'(1);

	always_comb begin
		sec_d  = cur_sec;
		band_d = cur_band;
		seg_d  = cur_seg;
		half_d = cur_half;
		base_d = cur_base;
		last_d = 1'b0;
		a_d    = '0;
		b_d    = '0;
		c_d    = '0;
		case (cur_sec)
			SEC_TOP: begin
				a_d   = '0;
				b_d   = IDX_W'(cur_seg) + IDX_W'(1);
				c_d   = IDX_W'(j) + IDX_W'(1);
				seg_d = j;
				if (wrap) begin
					band_d = '0;
					base_d = IDX_W'(1);
					sec_d  = (r_eff > R_W'(1)) ? SEC_BAND : SEC_BOTTOM;
				end
			end
			SEC_BAND: begin
				if (!cur_half) begin
					a_d    = ui;
					b_d    = li;
					c_d    = lj;
					half_d = 1'b1;
				end else begin
					a_d    = lj;
					b_d    = uj;
					c_d    = ui;
					half_d = 1'b0;
					seg_d  = j;
					if (wrap) begin
						band_d = band_inc;
						base_d = low_base;
						if ({1'b0, band_inc} + (R_W+1)'(1) >= {1'b0, r_eff})
							sec_d = SEC_BOTTOM;
					end
				end
			end
			SEC_BOTTOM: begin
				// the upper ring of the cap is the current band base
				a_d = low_base;
				b_d = ui;
				c_d = uj;
				if (wrap) begin
					last_d = 1'b1;
					sec_d  = SEC_TOP;
					band_d = '0;
					seg_d  = '0;
					half_d = 1'b0;
					base_d = IDX_W'(1);
				end else begin
					seg_d = j;
				end
			end
			default: begin
				sec_d  = SEC_TOP;
				band_d = '0;
				seg_d  = '0;
				half_d = 1'b0;
				base_d = IDX_W'(1);
			end
		endcase
	end

	assign req.ready = !out_valid_q || triangle.ready;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_TOP;
			band_q <= '0;
			seg_q  <= '0;
			half_q <= 1'b0;
			base_q <= IDX_W'(1);
		end else if (cfg_wr) begin
			sec_q  <= SEC_TOP;
			band_q <= '0;
			seg_q  <= '0;
			half_q <= 1'b0;
			base_q <= IDX_W'(1);
		end else if (accept) begin
			sec_q  <= sec_d;
			band_q <= band_d;
			seg_q  <= seg_d;
			half_q <= half_d;
			base_q <= base_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (triangle.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= a_d;
			b_q    <= b_d;
			c_q    <= c_d;
			last_q <= last_d;
		end
	end

	assign triangle.valid         = out_valid_q;
	assign triangle.first_index   = a_q;
	assign triangle.second_index  = b_q;
	assign triangle.third_index   = c_q;
	assign triangle.last_triangle = last_q;

	// a waiting triangle blocks the next request
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !triangle.ready) |-> !req.ready)
		else $error("request taken while output is stalled");

	// after the final triangle the walk is back at the top cap
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_d && !cfg_wr) |=>
		(sec_q == SEC_TOP && seg_q == '0 && base_q == IDX_W'(1)))
		else $error("sequence did not return to the top after the last triangle");

	// the second triangle of a segment exists only inside a band
	a_half_in_band: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> (sec_q == SEC_BAND))
		else $error("second-half flag set outside a band");

	// bands stop one short of the ring count
	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		(sec_q == SEC_BAND && !cfg_wr) |->
		({1'b0, band_q} + (R_W+1)'(1) < {1'b0, r_eff}))
		else $error("band number beyond the last band");

endmodule
